### rtl/ttea_pkg.sv
// ttea_pkg: widths, reset values, register codes and shared types of the
// two-tap echo adder. No dependencies; used by every file of the block.
`default_nettype none

package ttea_pkg;

   localparam int unsigned SAMPLE_W          = 16;
   localparam int unsigned DELAY_W           = 17;
   localparam int unsigned GAIN_W            = 16;
   localparam int unsigned GAIN_FRAC         = 15;
   localparam int unsigned PROD_W            = SAMPLE_W + GAIN_W;
   localparam int unsigned SCALED_W          = PROD_W - GAIN_FRAC;
   localparam int unsigned COUNT_W           = 18;
   localparam int unsigned CSR_DATA_W        = 32;
   localparam int unsigned CSR_ADDR_W        = 4;
   localparam int unsigned HISTORY_DEPTH_DEF = 131072;

   localparam logic [COUNT_W-1:0]  COUNT_MAX       = '1;
   localparam logic [DELAY_W-1:0]  DELAY_ONE_RESET = DELAY_W'(44100);
   localparam logic [DELAY_W-1:0]  DELAY_TWO_RESET = DELAY_W'(88200);
   localparam logic [GAIN_W-1:0]   GAIN_ONE_RESET  = GAIN_W'(6554);
   localparam logic [GAIN_W-1:0]   GAIN_TWO_RESET  = GAIN_W'(3277);

   typedef enum logic [1:0] {
      CSR_DELAY_ONE = 2'd0,
      CSR_DELAY_TWO = 2'd1,
      CSR_GAIN_ONE  = 2'd2,
      CSR_GAIN_TWO  = 2'd3
   } csr_index_type;

   // per-tap decision taken when the sample is accepted
   typedef struct packed {
      logic hit;    // tap reaches a sample of the current block
      logic zero;   // zero delay: tap scales the current sample
   } tap_ctrl_type;

endpackage

`default_nettype wire

### rtl/two_tap_echo_adder_core.sv
// two_tap_echo_adder_core: top level of the two-tap feedforward echo adder.
// Depends on ttea_pkg and ttea_history_ram.
//
// Usage:
//   req_* carries one 16-bit sample per transfer, with req_block_start high
//   on the first sample of a new buffer. rsp_* returns one sample per input:
//   the input plus both scaled echoes, wrapped to 16 bits. The csr_* port
//   holds the two delays (samples) and the two Q1.15 gains; write it only
//   while no sample is in flight.
//   Throughput is one sample per clock while rsp_stall is low. A result
//   goes through the memory read, the multiply, then sum and saturate into
//   the output register. The history ram takes one write and two tap reads
//   each cycle, so it sets the one-per-clock figure.
//   A stalled result holds in the output register; the stages behind it keep
//   filling, and req_stall rises only when all three stages are occupied.
//   Reset clears the pipeline, write pointer, sample count and registers
//   to their defaults. The history needs no clearing pass: a tap uses
//   only entries written since its block began.
`default_nettype none

module two_tap_echo_adder_core #(
   parameter int unsigned HISTORY_DEPTH = ttea_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // sample input
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ttea_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  wire logic                            req_block_start,
   // sample output
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [ttea_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ttea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ttea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ttea_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   // width holding a pointer, a delay and the depth without overflow
   localparam int unsigned CW = ((AW > ttea_pkg::DELAY_W) ? AW : ttea_pkg::DELAY_W) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

   // configuration registers
   logic [ttea_pkg::DELAY_W-1:0] delay_one_ff, delay_two_ff;
   logic [ttea_pkg::GAIN_W-1:0]  gain_one_ff, gain_two_ff;
   ttea_pkg::csr_index_type      csr_index;
   logic                         csr_write;

   // ring and block position
   logic [AW-1:0]                wp_ff, wp_in;
   logic [ttea_pkg::COUNT_W-1:0] seen_ff, seen_in, pos;

   // pipeline control
   logic en1, en2, en3, accept;
   logic v1_ff, v2_ff, rsp_valid_ff;

   // stage 1: read data and tap decisions
   logic [ttea_pkg::SAMPLE_W-1:0] cur1_ff, rd_one, rd_two;
   ttea_pkg::tap_ctrl_type        tap_one_in, tap_two_in, tap_one1_ff, tap_two1_ff;
   logic [AW-1:0]                 addr_one, addr_two;
   logic [ttea_pkg::SAMPLE_W-1:0] src_one, src_two;

   // stage 2: products
   logic [ttea_pkg::SAMPLE_W-1:0] cur2_ff;
   logic                          hit_one2_ff, hit_two2_ff;
   logic [ttea_pkg::PROD_W-1:0]   prod_one_ff, prod_one_in, prod_two_ff, prod_two_in;

   // stage 3: output
   logic [ttea_pkg::SCALED_W-1:0] scaled_one, scaled_two;
   logic [ttea_pkg::SAMPLE_W-1:0] echo_one, echo_two;
   logic [ttea_pkg::SAMPLE_W-1:0] sample_out_ff, sample_out_in;

   // ---------------------------------------------------------------- csr
   assign csr_index  = ttea_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         ttea_pkg::CSR_DELAY_ONE: csr_prdata = ttea_pkg::CSR_DATA_W'(delay_one_ff);
         ttea_pkg::CSR_DELAY_TWO: csr_prdata = ttea_pkg::CSR_DATA_W'(delay_two_ff);
         ttea_pkg::CSR_GAIN_ONE:  csr_prdata = ttea_pkg::CSR_DATA_W'(gain_one_ff);
         ttea_pkg::CSR_GAIN_TWO:  csr_prdata = ttea_pkg::CSR_DATA_W'(gain_two_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_one_ff <= ttea_pkg::DELAY_ONE_RESET;
         delay_two_ff <= ttea_pkg::DELAY_TWO_RESET;
         gain_one_ff  <= ttea_pkg::GAIN_ONE_RESET;
         gain_two_ff  <= ttea_pkg::GAIN_TWO_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ttea_pkg::CSR_DELAY_ONE: delay_one_ff <= csr_pwdata[ttea_pkg::DELAY_W-1:0];
            ttea_pkg::CSR_DELAY_TWO: delay_two_ff <= csr_pwdata[ttea_pkg::DELAY_W-1:0];
            ttea_pkg::CSR_GAIN_ONE:  gain_one_ff  <= csr_pwdata[ttea_pkg::GAIN_W-1:0];
            ttea_pkg::CSR_GAIN_TWO:  gain_two_ff  <= csr_pwdata[ttea_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   assign en3       = !rsp_valid_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         seen_ff      <= '0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) rsp_valid_ff <= v2_ff;
         if (accept) begin
            wp_ff   <= wp_in;
            seen_ff <= seen_in;
         end
      end
   end

   // ---------------------------------------------------------------- accept stage
   assign pos     = req_block_start ? '0 : seen_ff;
   assign seen_in = (pos == ttea_pkg::COUNT_MAX) ? pos : pos + 1'b1;
   assign wp_in   = (wp_ff == LAST_SLOT) ? '0 : wp_ff + AW'(1);

   function automatic ttea_pkg::tap_ctrl_type tap_ctrl(
      input logic [ttea_pkg::DELAY_W-1:0] delay,
      input logic [ttea_pkg::COUNT_W-1:0] at
   );
      ttea_pkg::tap_ctrl_type c;
      c.zero = (delay == '0);
      c.hit  = (ttea_pkg::COUNT_W'(delay) <= at) && (CW'(delay) < DEPTH_C);
      return c;
   endfunction

   // ring slot a tap reads; only used when the delay is below the depth
   function automatic logic [AW-1:0] tap_addr(
      input logic [AW-1:0]                wp,
      input logic [ttea_pkg::DELAY_W-1:0] delay
   );
      logic [CW-1:0] w;
      logic [CW-1:0] d;
      logic [CW-1:0] a;
      w = CW'(wp);
      d = CW'(delay);
      a = (w >= d) ? (w - d) : (w + DEPTH_C - d);
      return a[AW-1:0];
   endfunction

   assign tap_one_in = tap_ctrl(delay_one_ff, pos);
   assign tap_two_in = tap_ctrl(delay_two_ff, pos);
   assign addr_one   = tap_addr(wp_ff, delay_one_ff);
   assign addr_two   = tap_addr(wp_ff, delay_two_ff);

   // a used read slot equals the slot written in the same cycle only for a zero delay, which takes the
   // current sample instead; older samples were written at earlier edges, so no forwarding is needed
   ttea_history_ram #(
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock     (clock),
      .rd_en     (en1),
      .rd_addr_a (addr_one),
      .rd_addr_b (addr_two),
      .rd_data_a (rd_one),
      .rd_data_b (rd_two),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (req_sample_in)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         cur1_ff     <= req_sample_in;
         tap_one1_ff <= tap_one_in;
         tap_two1_ff <= tap_two_in;
      end
   end

   // ---------------------------------------------------------------- multiply stage
   assign src_one     = tap_one1_ff.zero ? cur1_ff : rd_one;
   assign src_two     = tap_two1_ff.zero ? cur1_ff : rd_two;
   assign prod_one_in = ttea_pkg::PROD_W'(src_one) * ttea_pkg::PROD_W'(gain_one_ff);
   assign prod_two_in = ttea_pkg::PROD_W'(src_two) * ttea_pkg::PROD_W'(gain_two_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         cur2_ff     <= cur1_ff;
         hit_one2_ff <= tap_one1_ff.hit;
         hit_two2_ff <= tap_two1_ff.hit;
         prod_one_ff <= prod_one_in;
         prod_two_ff <= prod_two_in;
      end
   end

   // ---------------------------------------------------------------- sum stage
   assign scaled_one = prod_one_ff[ttea_pkg::PROD_W-1:ttea_pkg::GAIN_FRAC];
   assign scaled_two = prod_two_ff[ttea_pkg::PROD_W-1:ttea_pkg::GAIN_FRAC];

   always_comb begin
      echo_one = '0;
      echo_two = '0;
      if (hit_one2_ff) begin
         echo_one = (|scaled_one[ttea_pkg::SCALED_W-1:ttea_pkg::SAMPLE_W]) ? '1
                    : scaled_one[ttea_pkg::SAMPLE_W-1:0];
      end
      if (hit_two2_ff) begin
         echo_two = (|scaled_two[ttea_pkg::SCALED_W-1:ttea_pkg::SAMPLE_W]) ? '1
                    : scaled_two[ttea_pkg::SAMPLE_W-1:0];
      end
      // wraps modulo 2^16
      sample_out_in = cur2_ff + echo_one + echo_two;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sample_out_ff <= sample_out_in;
      end
   end

   assign rsp_sample_out = sample_out_ff;

   // ---------------------------------------------------------------- checks
   a_empty_out_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled while output register empty");

   a_pointer_steps: assert property (@(posedge clock) disable iff (reset)
      accept |=> (wp_ff == (($past(wp_ff) == LAST_SLOT) ? '0 : $past(wp_ff) + AW'(1))))
      else $error("write pointer did not advance by one slot on transfer");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v2_ff))
      else $error("result presented without a sample in the multiply stage");

endmodule

`default_nettype wire

### rtl/ttea_history_ram.sv
// ttea_history_ram: sample history ring storage, one write port and two
// registered read ports. Depends on ttea_pkg for the sample width and default depth.
`default_nettype none

module ttea_history_ram #(
   parameter int unsigned DEPTH = ttea_pkg::HISTORY_DEPTH_DEF,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [AW-1:0]                 rd_addr_a,
   input  wire logic [AW-1:0]                 rd_addr_b,
   output logic      [ttea_pkg::SAMPLE_W-1:0] rd_data_a,
   output logic      [ttea_pkg::SAMPLE_W-1:0] rd_data_b,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [ttea_pkg::SAMPLE_W-1:0] wr_data
);

   logic [ttea_pkg::SAMPLE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire
